### rtl/core/rvdec_pkg.sv
// ----------------------------------------------------------------------------
// rvdec_pkg
// Opcodes, instruction numbers, format codes and the decoded request type
// shared by the RV32IM instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_TRAP   = 7'h6B;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [24:0] SYS_ECALL = 25'h0000000;
  localparam logic [24:0] SYS_MRET  = 25'h0604000;
  localparam logic [24:0] SYS_SRET  = 25'h0204000;

  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_I    = 3'd1;
  localparam logic [2:0] FMT_U    = 3'd2;
  localparam logic [2:0] FMT_S    = 3'd3;
  localparam logic [2:0] FMT_R    = 3'd4;
  localparam logic [2:0] FMT_J    = 3'd5;
  localparam logic [2:0] FMT_B    = 3'd6;

  localparam logic [5:0] OP_INVALID = 6'd0;
  localparam logic [5:0] OP_LB    = 6'd1;
  localparam logic [5:0] OP_LH    = 6'd2;
  localparam logic [5:0] OP_LW    = 6'd3;
  localparam logic [5:0] OP_LBU   = 6'd4;
  localparam logic [5:0] OP_LHU   = 6'd5;
  localparam logic [5:0] OP_SB    = 6'd6;
  localparam logic [5:0] OP_SH    = 6'd7;
  localparam logic [5:0] OP_SW    = 6'd8;
  localparam logic [5:0] OP_ADD   = 6'd9;
  localparam logic [5:0] OP_SUB   = 6'd10;
  localparam logic [5:0] OP_SLL   = 6'd11;
  localparam logic [5:0] OP_SLT   = 6'd12;
  localparam logic [5:0] OP_SLTU  = 6'd13;
  localparam logic [5:0] OP_XOR   = 6'd14;
  localparam logic [5:0] OP_SRL   = 6'd15;
  localparam logic [5:0] OP_SRA   = 6'd16;
  localparam logic [5:0] OP_OR    = 6'd17;
  localparam logic [5:0] OP_AND   = 6'd18;
  localparam logic [5:0] OP_MUL   = 6'd19;
  localparam logic [5:0] OP_MULH  = 6'd20;
  localparam logic [5:0] OP_MULHU = 6'd21;
  localparam logic [5:0] OP_DIV   = 6'd22;
  localparam logic [5:0] OP_DIVU  = 6'd23;
  localparam logic [5:0] OP_REM   = 6'd24;
  localparam logic [5:0] OP_REMU  = 6'd25;
  localparam logic [5:0] OP_ADDI  = 6'd26;
  localparam logic [5:0] OP_SLTI  = 6'd27;
  localparam logic [5:0] OP_SLTIU = 6'd28;
  localparam logic [5:0] OP_XORI  = 6'd29;
  localparam logic [5:0] OP_ORI   = 6'd30;
  localparam logic [5:0] OP_ANDI  = 6'd31;
  localparam logic [5:0] OP_SLLI  = 6'd32;
  localparam logic [5:0] OP_SRLI  = 6'd33;
  localparam logic [5:0] OP_SRAI  = 6'd34;
  localparam logic [5:0] OP_BEQ   = 6'd35;
  localparam logic [5:0] OP_BNE   = 6'd36;
  localparam logic [5:0] OP_BLT   = 6'd37;
  localparam logic [5:0] OP_BGE   = 6'd38;
  localparam logic [5:0] OP_BLTU  = 6'd39;
  localparam logic [5:0] OP_BGEU  = 6'd40;
  localparam logic [5:0] OP_ECALL = 6'd41;
  localparam logic [5:0] OP_MRET  = 6'd42;
  localparam logic [5:0] OP_SRET  = 6'd43;
  localparam logic [5:0] OP_CSRRW = 6'd44;
  localparam logic [5:0] OP_CSRRS = 6'd45;
  localparam logic [5:0] OP_AUIPC = 6'd46;
  localparam logic [5:0] OP_LUI   = 6'd47;
  localparam logic [5:0] OP_JAL   = 6'd48;
  localparam logic [5:0] OP_JALR  = 6'd49;
  localparam logic [5:0] OP_TRAP  = 6'd50;

  typedef struct packed {
    logic [5:0]         op;
    logic [2:0]         fmt;
    logic [4:0]         src1;
    logic [4:0]         src2;
    logic [4:0]         dest;
    logic signed [31:0] imm;
    logic               disc;
  } dec_t;

endpackage

### rtl/core/rvdec_decode.sv
// ----------------------------------------------------------------------------
// rvdec_decode
// Pattern match of one instruction word to instruction number, format,
// register indices, sign-extended immediate and discarded-write flag.
// ----------------------------------------------------------------------------
module rvdec_decode (
  input  logic [31:0]      word,
  output rvdec_pkg::dec_t  res
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [24:0] above;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [5:0]  op;
  logic [2:0]  fmt;

  assign opc   = word[6:0];
  assign f3    = word[14:12];
  assign f7    = word[31:25];
  assign above = word[31:7];
  assign rd    = word[11:7];
  assign rs1   = word[19:15];
  assign rs2   = word[24:20];

  always_comb begin
    op  = rvdec_pkg::OP_INVALID;
    fmt = rvdec_pkg::FMT_NONE;
    unique case (opc)
      rvdec_pkg::OPC_LOAD: begin
        fmt = rvdec_pkg::FMT_I;
        unique case (f3)
          3'd0:    op = rvdec_pkg::OP_LB;
          3'd1:    op = rvdec_pkg::OP_LH;
          3'd2:    op = rvdec_pkg::OP_LW;
          3'd4:    op = rvdec_pkg::OP_LBU;
          3'd5:    op = rvdec_pkg::OP_LHU;
          default: op = rvdec_pkg::OP_INVALID;
        endcase
      end
      rvdec_pkg::OPC_STORE: begin
        fmt = rvdec_pkg::FMT_S;
        unique case (f3)
          3'd0:    op = rvdec_pkg::OP_SB;
          3'd1:    op = rvdec_pkg::OP_SH;
          3'd2:    op = rvdec_pkg::OP_SW;
          default: op = rvdec_pkg::OP_INVALID;
        endcase
      end
      rvdec_pkg::OPC_OP: begin
        fmt = rvdec_pkg::FMT_R;
        if (f7 == rvdec_pkg::F7_BASE) begin
          unique case (f3)
            3'd0:    op = rvdec_pkg::OP_ADD;
            3'd1:    op = rvdec_pkg::OP_SLL;
            3'd2:    op = rvdec_pkg::OP_SLT;
            3'd3:    op = rvdec_pkg::OP_SLTU;
            3'd4:    op = rvdec_pkg::OP_XOR;
            3'd5:    op = rvdec_pkg::OP_SRL;
            3'd6:    op = rvdec_pkg::OP_OR;
            default: op = rvdec_pkg::OP_AND;
          endcase
        end else if (f7 == rvdec_pkg::F7_ALT) begin
          unique case (f3)
            3'd0:    op = rvdec_pkg::OP_SUB;
            3'd5:    op = rvdec_pkg::OP_SRA;
            default: op = rvdec_pkg::OP_INVALID;
          endcase
        end else if (f7 == rvdec_pkg::F7_MULDIV) begin
          unique case (f3)
            3'd0:    op = rvdec_pkg::OP_MUL;
            3'd1:    op = rvdec_pkg::OP_MULH;
            3'd3:    op = rvdec_pkg::OP_MULHU;
            3'd4:    op = rvdec_pkg::OP_DIV;
            3'd5:    op = rvdec_pkg::OP_DIVU;
            3'd6:    op = rvdec_pkg::OP_REM;
            3'd7:    op = rvdec_pkg::OP_REMU;
            default: op = rvdec_pkg::OP_INVALID;
          endcase
        end
      end
      rvdec_pkg::OPC_OPIMM: begin
        fmt = rvdec_pkg::FMT_I;
        unique case (f3)
          3'd0: op = rvdec_pkg::OP_ADDI;
          3'd2: op = rvdec_pkg::OP_SLTI;
          3'd3: op = rvdec_pkg::OP_SLTIU;
          3'd4: op = rvdec_pkg::OP_XORI;
          3'd6: op = rvdec_pkg::OP_ORI;
          3'd7: op = rvdec_pkg::OP_ANDI;
          3'd1: op = (f7 == rvdec_pkg::F7_BASE) ? rvdec_pkg::OP_SLLI : rvdec_pkg::OP_INVALID;
          default: begin
            if (f7 == rvdec_pkg::F7_BASE) op = rvdec_pkg::OP_SRLI;
            else if (f7 == rvdec_pkg::F7_ALT) op = rvdec_pkg::OP_SRAI;
            else op = rvdec_pkg::OP_INVALID;
          end
        endcase
      end
      rvdec_pkg::OPC_BRANCH: begin
        fmt = rvdec_pkg::FMT_B;
        unique case (f3)
          3'd0:    op = rvdec_pkg::OP_BEQ;
          3'd1:    op = rvdec_pkg::OP_BNE;
          3'd4:    op = rvdec_pkg::OP_BLT;
          3'd5:    op = rvdec_pkg::OP_BGE;
          3'd6:    op = rvdec_pkg::OP_BLTU;
          3'd7:    op = rvdec_pkg::OP_BGEU;
          default: op = rvdec_pkg::OP_INVALID;
        endcase
      end
      rvdec_pkg::OPC_SYSTEM: begin
        fmt = rvdec_pkg::FMT_I;
        if (above == rvdec_pkg::SYS_ECALL) op = rvdec_pkg::OP_ECALL;
        else if (above == rvdec_pkg::SYS_MRET) op = rvdec_pkg::OP_MRET;
        else if (above == rvdec_pkg::SYS_SRET) op = rvdec_pkg::OP_SRET;
        else if (f3 == 3'd1) op = rvdec_pkg::OP_CSRRW;
        else if (f3 == 3'd2) op = rvdec_pkg::OP_CSRRS;
        else op = rvdec_pkg::OP_INVALID;
      end
      rvdec_pkg::OPC_AUIPC: begin
        fmt = rvdec_pkg::FMT_U;
        op  = rvdec_pkg::OP_AUIPC;
      end
      rvdec_pkg::OPC_LUI: begin
        fmt = rvdec_pkg::FMT_U;
        op  = rvdec_pkg::OP_LUI;
      end
      rvdec_pkg::OPC_JAL: begin
        fmt = rvdec_pkg::FMT_J;
        op  = rvdec_pkg::OP_JAL;
      end
      rvdec_pkg::OPC_JALR: begin
        fmt = rvdec_pkg::FMT_I;
        op  = (f3 == 3'd0) ? rvdec_pkg::OP_JALR : rvdec_pkg::OP_INVALID;
      end
      rvdec_pkg::OPC_TRAP: begin
        fmt = rvdec_pkg::FMT_NONE;
        op  = rvdec_pkg::OP_TRAP;
      end
      default: begin
        fmt = rvdec_pkg::FMT_NONE;
        op  = rvdec_pkg::OP_INVALID;
      end
    endcase
    if (op == rvdec_pkg::OP_INVALID) fmt = rvdec_pkg::FMT_NONE;
  end

  always_comb begin
    res      = '0;
    res.op   = op;
    res.fmt  = fmt;
    unique case (fmt)
      rvdec_pkg::FMT_I: begin
        res.src1 = rs1;
        res.dest = rd;
        res.disc = (rd == 5'd0);
        res.imm  = {{20{word[31]}}, word[31:20]};
      end
      rvdec_pkg::FMT_U: begin
        res.dest = rd;
        res.disc = (rd == 5'd0);
        res.imm  = {word[31:12], 12'd0};
      end
      rvdec_pkg::FMT_S: begin
        res.src1 = rs1;
        res.dest = rs2;
        res.imm  = {{20{word[31]}}, word[31:25], word[11:7]};
      end
      rvdec_pkg::FMT_R: begin
        res.src1 = rs1;
        res.src2 = rs2;
        res.dest = rd;
        res.disc = (rd == 5'd0);
      end
      rvdec_pkg::FMT_J: begin
        res.dest = rd;
        res.disc = (rd == 5'd0);
        res.imm  = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
      end
      rvdec_pkg::FMT_B: begin
        res.src1 = rs1;
        res.src2 = rs2;
        res.imm  = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
      end
      default: begin
        res.src1 = 5'd0;
      end
    endcase
  end

endmodule

### rtl/core/rv32im_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_unit
// RV32IM instruction decoder: one instruction word in, one decoded request
// out, through an input register and a result register.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+----
//   in      | in_valid, in_stall, instr_word                 | in
//   out     | out_valid, out_stall, op_number, format,       | out
//           | src1_index, src2_index, dest_index, immediate, |
//           | dest_discarded                                 |
//
// One request per cycle sustained while out_stall is low.
// The decode sits between the input register and the result register.
// A stalled result holds the result stage; the input stage fills and then
// holds, so in_stall rises only when both are full.
// Synchronous reset empties both stages.
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        instr_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         op_number,
  output logic [2:0]         format,
  output logic [4:0]         src1_index,
  output logic [4:0]         src2_index,
  output logic [4:0]         dest_index,
  output logic signed [31:0] immediate,
  output logic               dest_discarded
);

  logic            word_valid;
  logic [31:0]     word;
  logic            res_valid;
  rvdec_pkg::dec_t res;
  rvdec_pkg::dec_t res_next;
  logic            res_hold;
  logic            word_hold;

  rvdec_decode u_decode (
    .word (word),
    .res  (res_next)
  );

  assign res_hold  = res_valid && out_stall;
  assign word_hold = word_valid && res_hold;
  assign in_stall  = word_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (!word_hold) word_valid <= in_valid;
      if (!res_hold) res_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!word_hold && in_valid) word <= instr_word;
    if (!res_hold && word_valid) res <= res_next;
  end

  assign out_valid      = res_valid;
  assign op_number      = res.op;
  assign format         = res.fmt;
  assign src1_index     = res.src1;
  assign src2_index     = res.src2;
  assign dest_index     = res.dest;
  assign immediate      = res.imm;
  assign dest_discarded = res.disc;

endmodule

### tb/sv/rvdec_checker.sv
// ----------------------------------------------------------------------------
// rvdec_checker
// Watches both channels of the RV32IM instruction decoder, decodes every
// accepted instruction word on its own, queues the decoded request and
// compares each accepted result field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module rvdec_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        instr_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [5:0]         op_number,
  input  logic [2:0]         format,
  input  logic [4:0]         src1_index,
  input  logic [4:0]         src2_index,
  input  logic [4:0]         dest_index,
  input  logic signed [31:0] immediate,
  input  logic               dest_discarded,
  output int                 fail_count,
  output int                 pending
);

  timeunit 1ns;
  timeprecision 1ps;

  rvdec_pkg::dec_t decoded_q [$];
  int   mismatches = 0;
  int   queued = 0;

  assign fail_count = mismatches;
  assign pending = queued;

  function automatic rvdec_pkg::dec_t decode_word(logic [31:0] w);
    rvdec_pkg::dec_t d;
    logic [2:0]      f3;
    logic [6:0]      f7;
    d = '0;
    f3 = w[14:12];
    f7 = w[31:25];
    d.op = rvdec_pkg::OP_INVALID;
    d.fmt = rvdec_pkg::FMT_NONE;
    case (w[6:0])
      rvdec_pkg::OPC_LOAD: begin
        d.fmt = rvdec_pkg::FMT_I;
        case (f3)
          3'd0: d.op = rvdec_pkg::OP_LB;
          3'd1: d.op = rvdec_pkg::OP_LH;
          3'd2: d.op = rvdec_pkg::OP_LW;
          3'd4: d.op = rvdec_pkg::OP_LBU;
          3'd5: d.op = rvdec_pkg::OP_LHU;
          default: ;
        endcase
      end
      rvdec_pkg::OPC_STORE: begin
        d.fmt = rvdec_pkg::FMT_S;
        case (f3)
          3'd0: d.op = rvdec_pkg::OP_SB;
          3'd1: d.op = rvdec_pkg::OP_SH;
          3'd2: d.op = rvdec_pkg::OP_SW;
          default: ;
        endcase
      end
      rvdec_pkg::OPC_OP: begin
        d.fmt = rvdec_pkg::FMT_R;
        if (f7 == rvdec_pkg::F7_BASE) begin
          case (f3)
            3'd0: d.op = rvdec_pkg::OP_ADD;
            3'd1: d.op = rvdec_pkg::OP_SLL;
            3'd2: d.op = rvdec_pkg::OP_SLT;
            3'd3: d.op = rvdec_pkg::OP_SLTU;
            3'd4: d.op = rvdec_pkg::OP_XOR;
            3'd5: d.op = rvdec_pkg::OP_SRL;
            3'd6: d.op = rvdec_pkg::OP_OR;
            default: d.op = rvdec_pkg::OP_AND;
          endcase
        end else if (f7 == rvdec_pkg::F7_ALT) begin
          if (f3 == 3'd0) d.op = rvdec_pkg::OP_SUB;
          else if (f3 == 3'd5) d.op = rvdec_pkg::OP_SRA;
        end else if (f7 == rvdec_pkg::F7_MULDIV) begin
          case (f3)
            3'd0: d.op = rvdec_pkg::OP_MUL;
            3'd1: d.op = rvdec_pkg::OP_MULH;
            3'd3: d.op = rvdec_pkg::OP_MULHU;
            3'd4: d.op = rvdec_pkg::OP_DIV;
            3'd5: d.op = rvdec_pkg::OP_DIVU;
            3'd6: d.op = rvdec_pkg::OP_REM;
            3'd7: d.op = rvdec_pkg::OP_REMU;
            default: ;
          endcase
        end
      end
      rvdec_pkg::OPC_OPIMM: begin
        d.fmt = rvdec_pkg::FMT_I;
        case (f3)
          3'd0: d.op = rvdec_pkg::OP_ADDI;
          3'd2: d.op = rvdec_pkg::OP_SLTI;
          3'd3: d.op = rvdec_pkg::OP_SLTIU;
          3'd4: d.op = rvdec_pkg::OP_XORI;
          3'd6: d.op = rvdec_pkg::OP_ORI;
          3'd7: d.op = rvdec_pkg::OP_ANDI;
          3'd1: if (f7 == rvdec_pkg::F7_BASE) d.op = rvdec_pkg::OP_SLLI;
          default: begin
            if (f7 == rvdec_pkg::F7_BASE) d.op = rvdec_pkg::OP_SRLI;
            else if (f7 == rvdec_pkg::F7_ALT) d.op = rvdec_pkg::OP_SRAI;
          end
        endcase
      end
      rvdec_pkg::OPC_BRANCH: begin
        d.fmt = rvdec_pkg::FMT_B;
        case (f3)
          3'd0: d.op = rvdec_pkg::OP_BEQ;
          3'd1: d.op = rvdec_pkg::OP_BNE;
          3'd4: d.op = rvdec_pkg::OP_BLT;
          3'd5: d.op = rvdec_pkg::OP_BGE;
          3'd6: d.op = rvdec_pkg::OP_BLTU;
          3'd7: d.op = rvdec_pkg::OP_BGEU;
          default: ;
        endcase
      end
      rvdec_pkg::OPC_SYSTEM: begin
        d.fmt = rvdec_pkg::FMT_I;
        if (w[31:7] == rvdec_pkg::SYS_ECALL) d.op = rvdec_pkg::OP_ECALL;
        else if (w[31:7] == rvdec_pkg::SYS_MRET) d.op = rvdec_pkg::OP_MRET;
        else if (w[31:7] == rvdec_pkg::SYS_SRET) d.op = rvdec_pkg::OP_SRET;
        else if (f3 == 3'd1) d.op = rvdec_pkg::OP_CSRRW;
        else if (f3 == 3'd2) d.op = rvdec_pkg::OP_CSRRS;
      end
      rvdec_pkg::OPC_AUIPC: begin
        d.fmt = rvdec_pkg::FMT_U;
        d.op = rvdec_pkg::OP_AUIPC;
      end
      rvdec_pkg::OPC_LUI: begin
        d.fmt = rvdec_pkg::FMT_U;
        d.op = rvdec_pkg::OP_LUI;
      end
      rvdec_pkg::OPC_JAL: begin
        d.fmt = rvdec_pkg::FMT_J;
        d.op = rvdec_pkg::OP_JAL;
      end
      rvdec_pkg::OPC_JALR: begin
        d.fmt = rvdec_pkg::FMT_I;
        if (f3 == 3'd0) d.op = rvdec_pkg::OP_JALR;
      end
      rvdec_pkg::OPC_TRAP: d.op = rvdec_pkg::OP_TRAP;
      default: ;
    endcase
    if (d.op == rvdec_pkg::OP_INVALID) d.fmt = rvdec_pkg::FMT_NONE;
    case (d.fmt)
      rvdec_pkg::FMT_I: begin
        d.src1 = w[19:15];
        d.dest = w[11:7];
        d.disc = (w[11:7] == 5'd0);
        d.imm = {{20{w[31]}}, w[31:20]};
      end
      rvdec_pkg::FMT_U: begin
        d.dest = w[11:7];
        d.disc = (w[11:7] == 5'd0);
        d.imm = {w[31:12], 12'd0};
      end
      rvdec_pkg::FMT_S: begin
        d.src1 = w[19:15];
        d.dest = w[24:20];
        d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      rvdec_pkg::FMT_R: begin
        d.src1 = w[19:15];
        d.src2 = w[24:20];
        d.dest = w[11:7];
        d.disc = (w[11:7] == 5'd0);
      end
      rvdec_pkg::FMT_J: begin
        d.dest = w[11:7];
        d.disc = (w[11:7] == 5'd0);
        d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      end
      rvdec_pkg::FMT_B: begin
        d.src1 = w[19:15];
        d.src2 = w[24:20];
        d.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      end
      default: ;
    endcase
    return d;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rvdec_pkg::dec_t want;
    if (!rst) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (decoded_q.size() == 0) begin
          $error("result with no request outstanding: op_number 0x%0h", op_number);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("op_number", 32'(want.op), 32'(op_number));
          check_field("format", 32'(want.fmt), 32'(format));
          check_field("src1_index", 32'(want.src1), 32'(src1_index));
          check_field("src2_index", 32'(want.src2), 32'(src2_index));
          check_field("dest_index", 32'(want.dest), 32'(dest_index));
          check_field("immediate", want.imm, immediate);
          check_field("dest_discarded", 32'(want.disc), 32'(dest_discarded));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        decoded_q.push_back(decode_word(instr_word));
      end
      queued = decoded_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the RV32IM instruction decoder with corner-case words and then with
// mostly well-formed random instructions, under three idling regimes on both
// channels, and gives the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_WORDS = 475;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        instr_word = 32'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         op_number;
  logic [2:0]         format;
  logic [4:0]         src1_index;
  logic [4:0]         src2_index;
  logic [4:0]         dest_index;
  logic signed [31:0] immediate;
  logic               dest_discarded;

  int fail_count;
  int pending;
  int send_idle_pct = 6;
  int recv_idle_pct = 66;
  int quiet_cycles = 0;
  logic [31:0] corner_words [25];

  rv32im_instruction_decoder_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .instr_word(instr_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .op_number(op_number),
    .format(format),
    .src1_index(src1_index),
    .src2_index(src2_index),
    .dest_index(dest_index),
    .immediate(immediate),
    .dest_discarded(dest_discarded)
  );

  rvdec_checker dec_chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .instr_word(instr_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .op_number(op_number),
    .format(format),
    .src1_index(src1_index),
    .src2_index(src2_index),
    .dest_index(dest_index),
    .immediate(immediate),
    .dest_discarded(dest_discarded),
    .fail_count(fail_count),
    .pending(pending)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] make_instr_word();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(0, 99) < 12) return w;
    case ($urandom_range(0, 10))
      0: w[6:0] = rvdec_pkg::OPC_LOAD;
      1: w[6:0] = rvdec_pkg::OPC_STORE;
      2: w[6:0] = rvdec_pkg::OPC_AUIPC;
      3: w[6:0] = rvdec_pkg::OPC_LUI;
      4, 5: begin
        w[6:0] = $urandom_range(0, 1) ? rvdec_pkg::OPC_OP : rvdec_pkg::OPC_OPIMM;
        case ($urandom_range(0, 3))
          0: w[31:25] = rvdec_pkg::F7_BASE;
          1: w[31:25] = rvdec_pkg::F7_ALT;
          2: w[31:25] = rvdec_pkg::F7_MULDIV;
          default: ;
        endcase
      end
      6: w[6:0] = rvdec_pkg::OPC_BRANCH;
      7: begin
        w[6:0] = rvdec_pkg::OPC_SYSTEM;
        case ($urandom_range(0, 5))
          0: w[31:7] = rvdec_pkg::SYS_ECALL;
          1: w[31:7] = rvdec_pkg::SYS_MRET;
          2: w[31:7] = rvdec_pkg::SYS_SRET;
          default: ;
        endcase
      end
      8: w[6:0] = rvdec_pkg::OPC_JAL;
      9: begin
        w[6:0] = rvdec_pkg::OPC_JALR;
        if ($urandom_range(0, 3) != 0) w[14:12] = 3'd0;
      end
      default: w[6:0] = rvdec_pkg::OPC_TRAP;
    endcase
    return w;
  endfunction

  task automatic send_word(logic [31:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    instr_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    corner_words = '{
      32'h00000000, 32'hFFFFFFFF, 32'h00000012, 32'h00000073, 32'h30200073,
      32'h10200073, 32'h00003073, 32'h00101073, 32'hFFFFA0F3, 32'h0000006B,
      32'hFFFFF06B, 32'h02002033, 32'h40001033, 32'h41FFD033, 32'h00001067,
      32'hFFF00067, 32'h800000B7, 32'hFFFFF017, 32'h8000006F, 32'h7FFFFFEF,
      32'hFE000FE3, 32'h7E0FFFE3, 32'h41F7D793, 32'h0207D793, 32'hFE0F8FA3
    };
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (corner_words[i]) send_word(corner_words[i]);
    // hold the sender until every result is back
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (PHASE_WORDS) send_word(make_instr_word());
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
